@@ hw/rtl/palette_grid_cell_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Palette grid cell decoder assertion macros
// Shared concurrent assertion helpers, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_GRID_CELL_DECODER_UNIT_DEFINES_SVH
`define PALETTE_GRID_CELL_DECODER_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define PGCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PGCD_NEVER(label, cond, msg) \
   `PGCD_ASSERT(label, !(cond), msg)

`endif

@@ hw/rtl/pgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette grid cell decoder package
// Payload types, mode and state codes, and format helper functions.
// ----------------------------------------------------------------------------
package pgcd_pkg;

   // Header byte that marks a fill grid.
   localparam logic [7:0] FILL_MARK = 8'd7;
   // Cells in one grid.
   localparam logic [6:0] GRID_CELLS = 7'd64;

   // Item kinds on the request channel.
   localparam logic REQ_HEADER = 1'b0;
   localparam logic REQ_DATA   = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] header_low;
      logic [7:0] header_high;
      logic [8:0] grid_number;
      logic       upper_half;
      logic [7:0] record_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] cell_address;
      logic [7:0]  cell_value;
      logic        last;
      logic        grid_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BIT1 = 3'd1,
      MODE_BIT2 = 3'd2,
      MODE_BIT4 = 3'd3,
      MODE_RAW  = 3'd4
   } mode_type;

   // Where the cells of the current burst take their value from.
   typedef enum logic [1:0] {
      SRC_FILL    = 2'd0,
      SRC_RAW     = 2'd1,
      SRC_PALETTE = 2'd2
   } cell_src_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } ctl_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic step;
   } ctl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic load_emits;
      logic final_cell;
      logic out_free;
   } dp_status_type;

   // Number of palette bytes that lead a record of the given format.
   function automatic logic [6:0] pal_size(input mode_type mode);
      case (mode)
         MODE_BIT1: pal_size = 7'd2;
         MODE_BIT2: pal_size = 7'd4;
         MODE_BIT4: pal_size = 7'd16;
         default:   pal_size = 7'd0;
      endcase
   endfunction

   // Number of cells packed into one index byte.
   function automatic logic [6:0] cells_per_byte(input mode_type mode);
      case (mode)
         MODE_BIT1: cells_per_byte = 7'd8;
         MODE_BIT2: cells_per_byte = 7'd4;
         MODE_BIT4: cells_per_byte = 7'd2;
         default:   cells_per_byte = 7'd1;
      endcase
   endfunction

   // Scattered volume address of cell n of a grid.
   function automatic logic [15:0] cell_addr(input logic half, input logic [8:0] grid,
                                             input logic [5:0] n);
      cell_addr = {half, grid[4:0], n[1:0], grid[8:7], n[5:4], grid[6:5], n[3:2]};
   endfunction

endpackage

@@ hw/rtl/pgcd_datapath.sv @@
// ----------------------------------------------------------------------------
// Palette grid cell decoder datapath
// Grid state, palette store, cell counters and the result output register.
// ----------------------------------------------------------------------------
`include "palette_grid_cell_decoder_unit_defines.svh"

module pgcd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pgcd_pkg::req_payload_type req_payload,
   input  pgcd_pkg::ctl_cmd_type     cmd,
   output pgcd_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pgcd_pkg::rsp_payload_type rsp_payload
);

   pgcd_pkg::mode_type      mode_ff, mode_in;
   pgcd_pkg::cell_src_type  src_ff, src_in;
   logic [6:0]              rbc_ff, rbc_in;
   logic [6:0]              cc_ff, cc_in;
   logic [6:0]              left_ff, left_in;
   logic [8:0]              base_ff, base_in;
   logic                    half_ff, half_in;
   logic [7:0]              shift_ff, shift_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pgcd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [7:0]              palette_ff [16];
   logic [7:0]              pal_rd_ff;
   logic                    pal_we;
   logic [3:0]              pal_idx_in;
   logic [7:0]              cell_value;
   logic                    out_free;
   logic                    load_emits;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Palette index of the following cell, taken from the low end of the next shift register value.
   always_comb begin
      case (mode_ff)
         pgcd_pkg::MODE_BIT1: pal_idx_in = {3'd0, shift_in[0]};
         pgcd_pkg::MODE_BIT2: pal_idx_in = {2'd0, shift_in[1:0]};
         default:             pal_idx_in = shift_in[3:0];
      endcase
   end

   // Value of the next cell from its source.
   always_comb begin
      case (src_ff)
         pgcd_pkg::SRC_PALETTE: cell_value = pal_rd_ff;
         default:               cell_value = shift_ff;
      endcase
   end

   // Load of an accepted item, or one cell step of the current burst.
   always_comb begin
      mode_in    = mode_ff;
      src_in     = src_ff;
      rbc_in     = rbc_ff;
      cc_in      = cc_ff;
      left_in    = left_ff;
      base_in    = base_ff;
      half_in    = half_ff;
      shift_in   = shift_ff;
      pal_we     = 1'b0;
      load_emits = 1'b0;
      if (req_payload.req_type == pgcd_pkg::REQ_HEADER) begin
         if (req_payload.header_low == pgcd_pkg::FILL_MARK) begin
            load_emits = (req_payload.header_high != 8'd0);
         end
      end else begin
         case (mode_ff)
            pgcd_pkg::MODE_RAW: begin
               load_emits = 1'b1;
            end
            pgcd_pkg::MODE_BIT1, pgcd_pkg::MODE_BIT2, pgcd_pkg::MODE_BIT4: begin
               load_emits = (rbc_ff >= pgcd_pkg::pal_size(mode_ff));
            end
            default: begin
               load_emits = 1'b0;
            end
         endcase
      end

      if (cmd.load) begin
         if (req_payload.req_type == pgcd_pkg::REQ_HEADER) begin
            base_in = req_payload.grid_number;
            half_in = req_payload.upper_half;
            rbc_in  = 7'd0;
            cc_in   = 7'd0;
            if (req_payload.header_low == pgcd_pkg::FILL_MARK) begin
               mode_in  = pgcd_pkg::MODE_IDLE;
               src_in   = pgcd_pkg::SRC_FILL;
               shift_in = req_payload.header_high;
               left_in  = pgcd_pkg::GRID_CELLS;
            end else begin
               mode_in = pgcd_pkg::mode_type'({1'b0, req_payload.header_low[1:0]} + 3'd1);
            end
         end else begin
            case (mode_ff)
               pgcd_pkg::MODE_RAW: begin
                  src_in   = pgcd_pkg::SRC_RAW;
                  shift_in = req_payload.record_byte;
                  left_in  = 7'd1;
                  rbc_in   = rbc_ff + 7'd1;
               end
               pgcd_pkg::MODE_BIT1, pgcd_pkg::MODE_BIT2, pgcd_pkg::MODE_BIT4: begin
                  rbc_in = rbc_ff + 7'd1;
                  if (rbc_ff < pgcd_pkg::pal_size(mode_ff)) begin
                     pal_we = 1'b1;
                  end else begin
                     src_in   = pgcd_pkg::SRC_PALETTE;
                     shift_in = req_payload.record_byte;
                     left_in  = pgcd_pkg::cells_per_byte(mode_ff);
                  end
               end
               default: begin
                  rbc_in = rbc_ff;
               end
            endcase
         end
      end else if (cmd.step) begin
         cc_in   = cc_ff + 7'd1;
         left_in = left_ff - 7'd1;
         case (mode_ff)
            pgcd_pkg::MODE_BIT1: shift_in = {1'b0, shift_ff[7:1]};
            pgcd_pkg::MODE_BIT2: shift_in = {2'b0, shift_ff[7:2]};
            pgcd_pkg::MODE_BIT4: shift_in = {4'b0, shift_ff[7:4]};
            default:             shift_in = shift_ff;
         endcase
         // The grid ends on its 64th cell.
         if (cc_ff == pgcd_pkg::GRID_CELLS - 7'd1) begin
            mode_in = pgcd_pkg::MODE_IDLE;
         end
      end
   end

   // Output register: a new cell moves in when the slot is empty or drained.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.step) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.cell_address = pgcd_pkg::cell_addr(half_ff, base_ff, cc_ff[5:0]);
         rsp_data_in.cell_value   = cell_value;
         rsp_data_in.last         = (left_ff == 7'd1);
         rsp_data_in.grid_done    = (cc_ff == pgcd_pkg::GRID_CELLS - 7'd1);
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pgcd_pkg::MODE_IDLE;
         rbc_ff       <= 7'd0;
         cc_ff        <= 7'd0;
         left_ff      <= 7'd0;
         base_ff      <= 9'd0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rbc_ff       <= rbc_in;
         cc_ff        <= cc_in;
         left_ff      <= left_in;
         base_ff      <= base_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Palette store, written in record order before any index is read.
   // The entry for the following cell is registered ahead of its step.
   always_ff @(posedge clock) begin
      if (pal_we) begin
         palette_ff[rbc_ff[3:0]] <= req_payload.record_byte;
      end
      pal_rd_ff <= palette_ff[pal_idx_in];
   end

   assign status.load_emits = load_emits;
   assign status.final_cell = (left_ff == 7'd1);
   assign status.out_free   = out_free;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_data_ff;

   `PGCD_ASSERT(a_step_has_cells, cmd.step |-> (left_ff != 7'd0), "cell step with empty burst")
   `PGCD_ASSERT(a_step_slot_free, cmd.step |-> out_free, "cell step overwrote a pending result")
   `PGCD_ASSERT(a_done_is_last, (rsp_valid_ff && rsp_data_ff.grid_done) |-> rsp_data_ff.last, "grid done without last")
   `PGCD_NEVER(a_count_range, cc_ff > pgcd_pkg::GRID_CELLS, "cell count beyond grid size")

endmodule

@@ hw/rtl/pgcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Palette grid cell decoder controller
// Accepts one item at a time and sequences the cell steps it produces.
// ----------------------------------------------------------------------------
module pgcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pgcd_pkg::dp_status_type status,
   output pgcd_pkg::ctl_cmd_type   cmd
);

   pgcd_pkg::ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         pgcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.load_emits) begin
                  state_in = pgcd_pkg::ST_EMIT;
               end
            end
         end
         pgcd_pkg::ST_EMIT: begin
            // One cell per cycle whenever the output slot can take it.
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.final_cell) begin
                  state_in = pgcd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pgcd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/palette_grid_cell_decoder_unit.sv @@
// Items are taken only while idle; a data byte is loaded, then its cells follow.
// One cell per cycle through the single output register while it can take it; an index
// byte gives 8, 4 or 2 cells, a raw byte 1 and a nonzero fill header 64, all before the next item.
// Palette bytes and non-filling headers give no cells. Output stalls pause cell steps.
// Reset is synchronous and active high; it clears the controller, counters and output valid.
// The palette store is not cleared and holds stale bytes until rewritten.
// ----------------------------------------------------------------------------
// Palette grid cell decoder unit
// Top level: decodes 4x4x4 palette, raw and fill grids into scattered cell writes.
// ----------------------------------------------------------------------------
module palette_grid_cell_decoder_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pgcd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pgcd_pkg::rsp_payload_type rsp_payload
);

   pgcd_pkg::ctl_cmd_type   cmd;
   pgcd_pkg::dp_status_type status;

   // Sequencing of item transfers and cell steps.
   pgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Grid state, palette and result register.
   pgcd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/palette_grid_cell_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Palette grid cell decoder unit testbench
// Sends grid headers and record bytes through the request channel and checks
// every cell transfer against a predicted write, with random idles on both sides.
// ----------------------------------------------------------------------------
module palette_grid_cell_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Format codes carried in the low two bits of the first header byte.
   localparam logic [1:0] FMT_BIT1 = 2'd0;
   localparam logic [1:0] FMT_BIT2 = 2'd1;
   localparam logic [1:0] FMT_BIT4 = 2'd2;
   localparam logic [1:0] FMT_RAW  = 2'd3;

   localparam int unsigned RANDOM_ITEMS = 230;

   // Tracks the decoder state and holds the cell writes still to come.
   class cell_scoreboard;
      pgcd_pkg::mode_type        mode;
      logic [7:0]                palette [16];
      int unsigned               bytes_taken;
      int unsigned               cells_out;
      logic [8:0]                grid;
      logic                      half;
      pgcd_pkg::rsp_payload_type pending [$];
      int unsigned               errors;
      int unsigned               results_seen;

      function new();
         mode         = pgcd_pkg::MODE_IDLE;
         bytes_taken  = 0;
         cells_out    = 0;
         grid         = '0;
         half         = 1'b0;
         errors       = 0;
         results_seen = 0;
         foreach (palette[i]) palette[i] = 8'h00;
      endfunction

      // Scattered volume address of cell n of the current grid.
      function logic [15:0] cell_location(int unsigned n);
         int unsigned hi;
         int unsigned lo;
         int unsigned a;
         hi = grid / 32;
         lo = grid % 32;
         a = (hi / 4) * 64 + (hi % 4) * 4 + lo * 1024;
         a += (n >> 4) * 16 + ((n >> 2) & 3) + (n & 3) * 256;
         if (half) a += 32768;
         return 16'(a);
      endfunction

      function void push_cell(int unsigned n, logic [7:0] val, logic is_last, logic done);
         pgcd_pkg::rsp_payload_type entry;
         entry.cell_address = cell_location(n);
         entry.cell_value   = val;
         entry.last         = is_last;
         entry.grid_done    = done;
         pending = {pending, entry};
      endfunction

      // Applies one accepted request transfer; returns 0 when the block ignores it.
      function bit note_input(pgcd_pkg::req_payload_type p);
         int unsigned idx_bits;
         int unsigned psize;
         int unsigned per;
         int unsigned idx;
         logic        done;
         if (p.req_type == pgcd_pkg::REQ_HEADER) begin
            grid        = p.grid_number;
            half        = p.upper_half;
            bytes_taken = 0;
            cells_out   = 0;
            if (p.header_low == pgcd_pkg::FILL_MARK) begin
               mode = pgcd_pkg::MODE_IDLE;
               if (p.header_high != 8'h00) begin
                  for (int n = 0; n < pgcd_pkg::GRID_CELLS; n++)
                     push_cell(n, p.header_high, n == pgcd_pkg::GRID_CELLS - 1,
                               n == pgcd_pkg::GRID_CELLS - 1);
               end
            end else begin
               mode = pgcd_pkg::mode_type'(p.header_low[1:0] + 3'd1);
            end
            return 1'b1;
         end

         if (mode == pgcd_pkg::MODE_IDLE) return 1'b0;

         // Raw grids carry one cell per byte.
         if (mode == pgcd_pkg::MODE_RAW) begin
            done = (cells_out + 1 >= pgcd_pkg::GRID_CELLS);
            push_cell(cells_out, p.record_byte, 1'b1, done);
            cells_out++;
            bytes_taken = (bytes_taken + 1) & 8'h7F;
            if (done) mode = pgcd_pkg::MODE_IDLE;
            return 1'b1;
         end

         case (mode)
            pgcd_pkg::MODE_BIT1: idx_bits = 1;
            pgcd_pkg::MODE_BIT2: idx_bits = 2;
            default:             idx_bits = 4;
         endcase
         psize = 1 << idx_bits;

         // Palette bytes lead the record.
         if (bytes_taken < psize) begin
            palette[bytes_taken & 15] = p.record_byte;
            bytes_taken++;
            return 1'b1;
         end

         // Index bytes unpack lowest bits first.
         per = 8 / idx_bits;
         for (int j = 0; j < per && cells_out < pgcd_pkg::GRID_CELLS; j++) begin
            idx  = (p.record_byte >> (j * idx_bits)) & (psize - 1);
            done = (cells_out + 1 >= pgcd_pkg::GRID_CELLS);
            push_cell(cells_out, palette[idx & 15], done || (j + 1 == per), done);
            cells_out++;
         end
         bytes_taken = (bytes_taken + 1) & 8'h7F;
         if (cells_out >= pgcd_pkg::GRID_CELLS) mode = pgcd_pkg::MODE_IDLE;
         return 1'b1;
      endfunction

      // Compares one cell transfer with the oldest predicted write.
      function void check_result(pgcd_pkg::rsp_payload_type got);
         pgcd_pkg::rsp_payload_type want;
         results_seen++;
         if (pending.size() == 0) begin
            $error("unexpected cell transfer: cell_address %04h cell_value %02h",
                   got.cell_address, got.cell_value);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.cell_address !== want.cell_address) begin
            $error("cell_address: expected %04h, actual %04h", want.cell_address,
                   got.cell_address);
            errors++;
         end
         if (got.cell_value !== want.cell_value) begin
            $error("cell_value: expected %02h, actual %02h", want.cell_value, got.cell_value);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
         end
         if (got.grid_done !== want.grid_done) begin
            $error("grid_done: expected %0b, actual %0b", want.grid_done, got.grid_done);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   pgcd_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   pgcd_pkg::rsp_payload_type rsp_payload;

   cell_scoreboard board = new();
   bit             quiet = 1'b0;
   int unsigned    effective_items = 0;
   int unsigned    grids_by_format [4] = '{default: 0};
   int unsigned    fill_headers = 0;

   palette_grid_cell_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver stalls at random except during the quiet stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = quiet || ($urandom_range(99) >= 37);
      end
   end

   // Every accepted cell transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_payload);
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // Presents one request and holds it until the transfer completes.
   task automatic send_item(input pgcd_pkg::req_payload_type p);
      while (!quiet && $urandom_range(99) < 37) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = p;
      do @(posedge clock); while (!req_ready);
      if (board.note_input(p)) effective_items++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [7:0] hl, input logic [7:0] hh,
                              input logic [8:0] grid, input logic half);
      pgcd_pkg::req_payload_type p;
      p.req_type    = pgcd_pkg::REQ_HEADER;
      p.header_low  = hl;
      p.header_high = hh;
      p.grid_number = grid;
      p.upper_half  = half;
      p.record_byte = 8'($urandom);
      if (hl == pgcd_pkg::FILL_MARK) fill_headers++;
      send_item(p);
   endtask

   // Data items carry random junk in the header fields.
   task automatic send_byte(input logic [7:0] b);
      pgcd_pkg::req_payload_type p;
      p.req_type    = pgcd_pkg::REQ_DATA;
      p.header_low  = 8'($urandom);
      p.header_high = 8'($urandom);
      p.grid_number = 9'($urandom);
      p.upper_half  = 1'($urandom);
      p.record_byte = b;
      send_item(p);
   endtask

   // One grid of the given format with random content, sometimes cut short.
   task automatic run_grid(input logic [1:0] fmt);
      int unsigned pal_n;
      int unsigned idx_n;
      int unsigned total;
      int unsigned cut;
      logic [7:0]  hl;
      case (fmt)
         FMT_BIT1: begin pal_n = 2;  idx_n = 8;  end
         FMT_BIT2: begin pal_n = 4;  idx_n = 16; end
         FMT_BIT4: begin pal_n = 16; idx_n = 32; end
         default:  begin pal_n = 0;  idx_n = 64; end
      endcase
      total = pal_n + idx_n;
      cut   = total;
      if ($urandom_range(99) < 20) cut = $urandom_range(total - 1, 0);
      do hl = {6'($urandom), fmt}; while (hl == pgcd_pkg::FILL_MARK);
      send_header(hl, 8'($urandom), 9'($urandom), 1'($urandom));
      grids_by_format[fmt]++;
      for (int n = 0; n < cut; n++) send_byte(8'($urandom));
      // Stray bytes after a finished grid are dropped by the block.
      if (cut == total && $urandom_range(99) < 25) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned start_items;
      int unsigned pick;
      int unsigned progress;
      bit          drained;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: idle byte, fills, a full 1-bit grid, abandoned grids.
      send_byte(8'hFF);
      send_header(pgcd_pkg::FILL_MARK, 8'hFF, 9'h1FF, 1'b1);
      send_header(pgcd_pkg::FILL_MARK, 8'h00, 9'h0AA, 1'b0);
      send_header({6'h00, FMT_BIT1}, 8'h00, 9'h000, 1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'h0F);
      send_byte(8'hF0);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h3C);
      send_header({6'h3F, FMT_RAW}, 8'hFF, 9'h1FF, 1'b1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header({6'h3F, FMT_BIT2}, 8'h00, 9'h155, 1'b0);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(8'hE4);
      send_header({6'h3F, FMT_BIT4}, 8'h80, 9'h0AA, 1'b1);

      // Random part: mostly well-formed grids, with fills and stray bytes mixed in.
      start_items = effective_items;
      drained     = 1'b0;
      progress    = 0;
      while (progress < RANDOM_ITEMS) begin
         quiet = (progress >= 90 && progress < 150);
         if (!drained && progress >= 180) begin
            wait_for_drain();
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 32)      run_grid(FMT_BIT1);
         else if (pick < 59) run_grid(FMT_BIT2);
         else if (pick < 77) run_grid(FMT_BIT4);
         else if (pick < 90) run_grid(FMT_RAW);
         else if (pick < 95) send_header(pgcd_pkg::FILL_MARK,
                                         ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                                         9'($urandom), 1'($urandom));
         else                send_byte(8'($urandom));
         progress = effective_items - start_items;
      end
      quiet = 1'b0;

      // Let the last cells come out, then allow for a trailing fill burst.
      wait_for_drain();
      repeat (80) @(negedge clock);
      if (board.pending.size() != 0) begin
         $error("%0d predicted cell writes never arrived", board.pending.size());
         board.errors++;
      end

      $display("Run: %0d effective request transfers, %0d cell transfers checked.",
               effective_items, board.results_seen);
      $display("Grids: %0d 1-bit, %0d 2-bit, %0d 4-bit, %0d raw, %0d fill headers.",
               grids_by_format[FMT_BIT1], grids_by_format[FMT_BIT2],
               grids_by_format[FMT_BIT4], grids_by_format[FMT_RAW], fill_headers);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
